// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; the top-level file includes them.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked while reset is released, sampled on the rising clock edge.
`define NDDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define NDDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define NDDF_ASSERT(lbl, prop, msg)
`define NDDF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/nddf_pkg.sv
package nddf_pkg;

  // Field widths.
  localparam int TIME_W     = 40;
  localparam int HASH_W     = 64;
  localparam int Q_W        = 17;
  localparam int WIN_W      = 16;
  localparam int HAM_W      = 7;
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int WINDOW_DEPTH_DEF = 16;

  localparam logic [Q_W-1:0]   Q_ONE     = 17'h10000;
  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  // Register reset values.
  localparam logic [Q_W-1:0]   MIN_SHARP_RST   = 17'd0;
  localparam logic [Q_W-1:0]   BRIGHT_LOW_RST  = 17'd5243;
  localparam logic [Q_W-1:0]   BRIGHT_HIGH_RST = 17'd60293;
  localparam logic [WIN_W-1:0] DUP_WINDOW_RST  = 16'd1000;
  localparam logic [HAM_W-1:0] MAX_HAM_RST     = 7'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SHARP   = 3'd0,
    REG_BRIGHT_LOW  = 3'd1,
    REG_BRIGHT_HIGH = 3'd2,
    REG_DUP_WINDOW  = 3'd3,
    REG_MAX_HAM     = 3'd4
  } cfg_reg_t;

  // Sequencer states: take the item, expire, count distances, decide.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXP,
    ST_CNT,
    ST_DEC
  } state_t;

  // Strobes broadcast to every cell of the window row.
  typedef struct packed {
    logic exp_en;
    logic cnt_en;
    logic ins_en;
  } cell_ctrl_t;

  // Number of set bits of a 64-bit word, counted per byte, then summed.
  function automatic logic [HAM_W-1:0] popcount64(input logic [HASH_W-1:0] v);
    logic [3:0]       byte_cnt;
    logic [HAM_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < HASH_W / 8; b++) begin
      byte_cnt = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt = byte_cnt + {3'b000, v[b*8+k]};
      end
      sum = sum + {3'b000, byte_cnt};
    end
    return sum;
  endfunction

  // Limit a Q1.16 value to 1.0.
  function automatic logic [Q_W-1:0] clamp_q(input logic [Q_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

// File: rtl/nddf_cell.sv
module nddf_cell
  import nddf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [TIME_W-1:0] frm_time,
  input  logic [HASH_W-1:0] frm_hash,
  input  logic [WIN_W-1:0]  dup_window,
  input  logic [HAM_W-1:0]  max_ham,
  // Neighbor on the newer side.
  input  logic [HASH_W-1:0] prev_hash,
  input  logic [TIME_W-1:0] prev_time,
  input  logic              prev_live,
  input  logic              shift_in,
  input  logic              dup_in,
  // Toward the neighbor on the older side.
  output logic [HASH_W-1:0] hash_out,
  output logic [TIME_W-1:0] time_out,
  output logic              live_out,
  output logic              shift_out,
  output logic              dup_out
);

  logic [HASH_W-1:0] hash_r;
  logic [TIME_W-1:0] time_r;
  logic              live_r;
  logic              live_nxt;
  logic [HAM_W-1:0]  dist_r;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              load;

  // Age test; an entry newer than the frame has no age.
  assign age     = frm_time - time_r;
  assign expired = (frm_time >= time_r) && (age >= {{(TIME_W-WIN_W){1'b0}}, dup_window});

  // A new entry ripples in up to and including the first free slot.
  assign load = ctrl.ins_en && shift_in;

  always_comb begin
    live_nxt = live_r;
    if (load) begin
      live_nxt = prev_live;
    end else if (ctrl.exp_en && expired) begin
      live_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  // Stored fingerprint and timestamp.
  always_ff @(posedge clk) begin
    if (load) begin
      hash_r <= prev_hash;
      time_r <= prev_time;
    end
  end

  // Hamming distance to the frame under test.
  always_ff @(posedge clk) begin
    if (ctrl.cnt_en) begin
      dist_r <= popcount64(hash_r ^ frm_hash);
    end
  end

  assign hash_out  = hash_r;
  assign time_out  = time_r;
  assign live_out  = live_r;
  assign shift_out = shift_in && live_r;
  assign dup_out   = dup_in || (live_r && (dist_r <= max_ham));

endmodule

// File: rtl/nddf_chain.sv
module nddf_chain
  import nddf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [TIME_W-1:0] frm_time,
  input  logic [HASH_W-1:0] frm_hash,
  input  logic [WIN_W-1:0]  dup_window,
  input  logic [HAM_W-1:0]  max_ham,
  output logic              dup
);

  // Links between neighbors; link 0 carries the incoming frame.
  logic [HASH_W-1:0] hash_w  [WINDOW_DEPTH+1];
  logic [TIME_W-1:0] time_w  [WINDOW_DEPTH+1];
  logic              live_w  [WINDOW_DEPTH+1];
  logic              shift_w [WINDOW_DEPTH+1];
  logic              dup_w   [WINDOW_DEPTH+1];

  assign hash_w[0]  = frm_hash;
  assign time_w[0]  = frm_time;
  assign live_w[0]  = 1'b1;
  assign shift_w[0] = 1'b1;
  assign dup_w[0]   = 1'b0;

  // Row of cells, newest entry in cell 0, oldest toward the end.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    nddf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .frm_time   (frm_time),
      .frm_hash   (frm_hash),
      .dup_window (dup_window),
      .max_ham    (max_ham),
      .prev_hash  (hash_w[i]),
      .prev_time  (time_w[i]),
      .prev_live  (live_w[i]),
      .shift_in   (shift_w[i]),
      .dup_in     (dup_w[i]),
      .hash_out   (hash_w[i+1]),
      .time_out   (time_w[i+1]),
      .live_out   (live_w[i+1]),
      .shift_out  (shift_w[i+1]),
      .dup_out    (dup_w[i+1])
    );
  end

  assign dup = dup_w[WINDOW_DEPTH];

endmodule

// File: rtl/near_duplicate_frame_filter_top.sv
// An accepted item passes the expire, distance and decide steps through the row of window
// cells; its result is loaded into the output register when the decide step completes.
// A new item is taken only once the sequencer is back in its idle step.
// A waiting result does not block the next item; a result still unread when
// the next decision is due holds the sequencer in its decide step.
// Reset (synchronous, rst_n low): window empty, kept count zero, registers at defaults.
`include "assert_macros.svh"

module near_duplicate_frame_filter_top
  import nddf_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Frame input.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [143:0]          in_tdata,  // time_ms[39:0], frame_hash[103:40],
                                           // frame_sharpness[120:104],
                                           // frame_brightness[137:121], zero pad
  input  logic [1:0]            in_tuser,  // image_ok[0], anchor[1]
  // Result output.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata, // accepted[0], frame_number[24:1],
                                           // was_duplicate[25], quality_pass[26], zero pad
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [Q_W-1:0]   min_sharp_r;
  logic [Q_W-1:0]   bright_low_r;
  logic [Q_W-1:0]   bright_high_r;
  logic [WIN_W-1:0] dup_window_r;
  logic [HAM_W-1:0] max_ham_r;

  logic [TIME_W-1:0] time_r;
  logic [HASH_W-1:0] hash_r;
  logic [Q_W-1:0]    sharp_r;
  logic [Q_W-1:0]    bright_r;
  logic              ok_r;
  logic              anc_r;

  logic [CNT_W-1:0] kept_r, kept_nxt;
  logic             out_valid_r;
  logic             acc_out_r;
  logic [CNT_W-1:0] num_out_r;
  logic             dup_out_r;
  logic             qpass_out_r;

  logic       in_fire;
  logic       dec_go;
  logic       dup;
  logic       qpass;
  logic       acc;
  cell_ctrl_t ctrl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sharp_r   <= MIN_SHARP_RST;
      bright_low_r  <= BRIGHT_LOW_RST;
      bright_high_r <= BRIGHT_HIGH_RST;
      dup_window_r  <= DUP_WINDOW_RST;
      max_ham_r     <= MAX_HAM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_SHARP:   min_sharp_r   <= cfg_data;
        REG_BRIGHT_LOW:  bright_low_r  <= cfg_data;
        REG_BRIGHT_HIGH: bright_high_r <= cfg_data;
        REG_DUP_WINDOW:  dup_window_r  <= cfg_data[WIN_W-1:0];
        REG_MAX_HAM:     max_ham_r     <= cfg_data[HAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      time_r   <= in_tdata[39:0];
      hash_r   <= in_tdata[103:40];
      sharp_r  <= in_tdata[120:104];
      bright_r <= in_tdata[137:121];
      ok_r     <= in_tuser[0];
      anc_r    <= in_tuser[1];
    end
  end

  // Decision, taken when the output register is free.
  assign dec_go = (state_r == ST_DEC) && (!out_valid_r || out_tready);
  assign qpass  = (clamp_q(sharp_r) >= clamp_q(min_sharp_r))
               && (clamp_q(bright_r) >= bright_low_r)
               && (clamp_q(bright_r) <= bright_high_r);
  assign acc    = ok_r && (anc_r || (qpass && !dup));

  always_comb begin
    kept_nxt = kept_r;
    if (dec_go && acc && (kept_r != COUNT_MAX)) begin
      kept_nxt = kept_r + 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ctrl.exp_en = 1'b0;
    ctrl.cnt_en = 1'b0;
    ctrl.ins_en = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        ctrl.exp_en = 1'b1;
        state_nxt   = ST_CNT;
      end
      ST_CNT: begin
        ctrl.cnt_en = 1'b1;
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        ctrl.ins_en = dec_go && acc;
        if (dec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Window store.
  nddf_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .frm_time   (time_r),
    .frm_hash   (hash_r),
    .dup_window (dup_window_r),
    .max_ham    (max_ham_r),
    .dup        (dup)
  );

  // Kept-frame counter and output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kept_r <= kept_nxt;
      if (dec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (dec_go) begin
      acc_out_r   <= acc;
      num_out_r   <= acc ? kept_nxt : '0;
      dup_out_r   <= dup;
      qpass_out_r <= qpass;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, qpass_out_r, dup_out_r, num_out_r, acc_out_r};

  // Only one item is in the sequencer at a time.
  `NDDF_ASSERT(a_one_in_flight, in_fire |=> !in_tready ##1 !in_tready, "second item taken while busy")
  // A kept frame carries a nonzero number, a dropped one carries zero.
  `NDDF_ASSERT(a_number_matches, out_valid_r |-> (acc_out_r == (num_out_r != '0)), "frame number disagrees with accept flag")
  // A new result appears only out of the decide step.
  `NDDF_ASSERT(a_result_from_dec, $rose(out_valid_r) |-> ($past(state_r) == ST_DEC), "result appeared outside decide step")

endmodule

// File: tb/near_duplicate_frame_filter_top_tb.sv
`timescale 1ns / 100ps

module near_duplicate_frame_filter_top_tb;
  import nddf_pkg::*;

  localparam int DEPTH           = WINDOW_DEPTH_DEF;
  localparam int Q_MAX           = (1 << Q_W) - 1;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int DIRECTED_ROWS   = 17;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_PHASE      = 3;
  localparam int HOLD_AT_ITEM    = 30;
  localparam int QUIET_PHASE     = 4;
  localparam int TOP_TIME_PHASE  = 5;
  localparam int CYCLE_LIMIT     = 400000;
  localparam logic [TIME_W-1:0] TIME_TOP      = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_TOP_BASE = 40'hFF_FF00_0000;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [HASH_W-1:0] hash;
    logic [Q_W-1:0]    sharpness;
    logic [Q_W-1:0]    brightness;
    logic              image_ok;
    logic              anchor;
  } frame_t;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] frame_number;
    logic             was_duplicate;
    logic             quality_pass;
  } verdict_t;

  typedef struct packed {
    frame_t   frame;
    logic     typed;
    verdict_t verdict;
  } directed_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_sharp;
    logic [CFG_DATA_W-1:0] bright_low;
    logic [CFG_DATA_W-1:0] bright_high;
    logic [CFG_DATA_W-1:0] window;
    logic [CFG_DATA_W-1:0] max_ham;
    logic                  pick_random;
  } settings_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [143:0]          in_tdata;   // time_ms, frame_hash, frame_sharpness,
                                     // frame_brightness, zero pad
  logic [1:0]            in_tuser;   // image_ok, anchor
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;  // accepted, frame_number, was_duplicate,
                                     // quality_pass, zero pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  near_duplicate_frame_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's registers and window store.
  logic [Q_W-1:0]    set_min_sharp;
  logic [Q_W-1:0]    set_bright_low;
  logic [Q_W-1:0]    set_bright_high;
  logic [WIN_W-1:0]  set_window;
  logic [HAM_W-1:0]  set_max_ham;
  logic [HASH_W-1:0] win_hash [DEPTH];
  logic [TIME_W-1:0] win_time [DEPTH];
  int                win_count;
  logic [CNT_W-1:0]  kept_total;

  verdict_t pending_verdicts [$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       gaps_enabled = 1'b1;
  bit       stalls_enabled = 1'b1;
  bit       hold_request = 1'b0;
  int       hold_left = 0;

  // Directed frames; the first rows run under reset defaults and their
  // verdicts follow directly from the thresholds and hash distances.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{40'd0, 64'h0, 17'd0, 17'd30000, 1'b1, 1'b0}, 1'b1, '{1'b1, 24'd1, 1'b0, 1'b1}},
    '{'{40'd0, 64'h0, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b1, '{1'b0, 24'd0, 1'b1, 1'b1}},
    '{'{40'd1, 64'hF, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b1, '{1'b0, 24'd0, 1'b1, 1'b1}},
    '{'{40'd2, 64'h1F, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b1, '{1'b1, 24'd2, 1'b0, 1'b1}},
    '{'{40'd3, 64'hFFFF_FFFF_FFFF_FFFF, 17'd40000, 17'd30000, 1'b0, 1'b1}, 1'b1,
      '{1'b0, 24'd0, 1'b0, 1'b1}},
    '{'{40'd4, 64'h0, 17'd40000, 17'd30000, 1'b1, 1'b1}, 1'b1, '{1'b1, 24'd3, 1'b1, 1'b1}},
    '{'{40'd5, 64'hFFFF_FFFF_FFFF_FFFF, 17'd40000, 17'd5242, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 24'd0, 1'b0, 1'b0}},
    '{'{40'd6, 64'hFFFF_FFFF_FFFF_FFFF, 17'd40000, 17'd5243, 1'b1, 1'b0}, 1'b1,
      '{1'b1, 24'd4, 1'b0, 1'b1}},
    '{'{40'd7, 64'hFFFF_0000_FFFF_0000, 17'd40000, 17'd60293, 1'b1, 1'b0}, 1'b1,
      '{1'b1, 24'd5, 1'b0, 1'b1}},
    '{'{40'd8, 64'hAAAA_AAAA_AAAA_AAAA, 17'd40000, 17'd60294, 1'b1, 1'b0}, 1'b1,
      '{1'b0, 24'd0, 1'b0, 1'b0}},
    '{'{40'd9, 64'h5555_5555_5555_5555, 17'd131071, 17'd131071, 1'b1, 1'b0}, 1'b0, '0},
    '{'{40'd10, 64'h0123_4567_89AB_CDEF, 17'd131071, 17'd30000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{40'd1000, 64'h0, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{40'd1004, 64'h0, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{40'hFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 17'd65536, 17'd65536, 1'b1, 1'b1},
      1'b0, '0},
    '{'{40'd2000, 64'h0123_4567_89AB_CDEF, 17'd40000, 17'd30000, 1'b1, 1'b0}, 1'b0, '0},
    '{'{40'd2000, 64'hFEDC_BA98_7654_3210, 17'd0, 17'd65536, 1'b0, 1'b0}, 1'b0, '0}
  };

  // Register settings per random phase, extremes first.
  settings_t phase_settings [PHASES] = '{
    '{17'd0, 17'd0, 17'd65536, 17'd65535, 17'd0, 1'b0},
    '{17'd131071, 17'd0, 17'd131071, 17'd0, 17'd0, 1'b0},
    '{17'd65536, 17'd65536, 17'd65536, 17'd1, 17'd127, 1'b0},
    '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b1},
    '{17'd20000, 17'd3000, 17'd62000, 17'd500, 17'd6, 1'b0},
    '{17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b1}
  };

  // Work out the verdict for one frame and advance the shadow store.
  task automatic judge_frame(input frame_t f, output verdict_t v);
    int             survivors;
    logic [Q_W-1:0] sharp;
    logic [Q_W-1:0] bright;
    logic [Q_W-1:0] sharp_floor;
    survivors = 0;
    v = '0;
    // Drop entries whose age reached the window; entries from the future stay.
    for (int i = 0; i < win_count; i++) begin
      if (!(f.time_ms >= win_time[i] &&
            f.time_ms - win_time[i] >= {{(TIME_W-WIN_W){1'b0}}, set_window})) begin
        win_hash[survivors] = win_hash[i];
        win_time[survivors] = win_time[i];
        survivors++;
      end
    end
    win_count = survivors;
    for (int i = 0; i < win_count; i++) begin
      if ($countones(f.hash ^ win_hash[i]) <= set_max_ham) begin
        v.was_duplicate = 1'b1;
      end
    end
    sharp       = (f.sharpness > Q_ONE) ? Q_ONE : f.sharpness;
    bright      = (f.brightness > Q_ONE) ? Q_ONE : f.brightness;
    sharp_floor = (set_min_sharp > Q_ONE) ? Q_ONE : set_min_sharp;
    v.quality_pass = (sharp >= sharp_floor) && (bright >= set_bright_low)
                     && (bright <= set_bright_high);
    v.accepted = f.image_ok && (f.anchor || (v.quality_pass && !v.was_duplicate));
    if (v.accepted) begin
      // A full store loses its oldest entry.
      if (win_count >= DEPTH) begin
        for (int i = 1; i < DEPTH; i++) begin
          win_hash[i-1] = win_hash[i];
          win_time[i-1] = win_time[i];
        end
        win_count = DEPTH - 1;
      end
      win_hash[win_count] = f.hash;
      win_time[win_count] = f.time_ms;
      win_count++;
      if (kept_total != COUNT_MAX) begin
        kept_total = kept_total + 1'b1;
      end
      v.frame_number = kept_total;
    end
  endtask

  // Offer one item, wait for it to be taken, then queue its verdict.
  task automatic send_frame(input frame_t f, input logic typed, input verdict_t typed_verdict);
    verdict_t v;
    while (gaps_enabled && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, f.brightness, f.sharpness, f.hash, f.time_ms};
    in_tuser  <= {f.anchor, f.image_ok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    judge_frame(f, v);
    if (typed) begin
      v = typed_verdict;
    end
    pending_verdicts.push_back(v);
  endtask

  // Write every register index, the spare ones included, back to back.
  task automatic program_settings(input settings_t s);
    logic [CFG_DATA_W-1:0] word;
    for (int idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
      case (cfg_reg_t'(idx))
        REG_MIN_SHARP:   word = s.min_sharp;
        REG_BRIGHT_LOW:  word = s.bright_low;
        REG_BRIGHT_HIGH: word = s.bright_high;
        REG_DUP_WINDOW:  word = s.window;
        REG_MAX_HAM:     word = s.max_ham;
        default:         word = CFG_DATA_W'($urandom_range(0, Q_MAX));
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx[CFG_IDX_W-1:0];
      cfg_data  <= word;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (cfg_reg_t'(idx))
        REG_MIN_SHARP:   set_min_sharp   = word;
        REG_BRIGHT_LOW:  set_bright_low  = word;
        REG_BRIGHT_HIGH: set_bright_high = word;
        REG_DUP_WINDOW:  set_window      = word[WIN_W-1:0];
        REG_MAX_HAM:     set_max_ham     = word[HAM_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    <= HOLD_CYCLES;
      hold_request <= 1'b0;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(stalls_enabled && $urandom_range(0, 99) < 7);
    end
  end

  // Compare each result item with the oldest queued verdict.
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[0], out_tdata[24:1], out_tdata[25], out_tdata[26]};
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, got);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted expected %0b, got %0b", $time, want.accepted, got.accepted);
          fail_count++;
        end
        if (got.frame_number !== want.frame_number) begin
          $display("%0t: frame_number expected %0d, got %0d", $time,
                   want.frame_number, got.frame_number);
          fail_count++;
        end
        if (got.was_duplicate !== want.was_duplicate) begin
          $display("%0t: was_duplicate expected %0b, got %0b", $time,
                   want.was_duplicate, got.was_duplicate);
          fail_count++;
        end
        if (got.quality_pass !== want.quality_pass) begin
          $display("%0t: quality_pass expected %0b, got %0b", $time,
                   want.quality_pass, got.quality_pass);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    settings_t         s;
    frame_t            f;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] stride;
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] recent_hashes [$];
    int                pick;
    int                flips;
    int                bitpos;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    // Shadow state after reset.
    set_min_sharp   = MIN_SHARP_RST;
    set_bright_low  = BRIGHT_LOW_RST;
    set_bright_high = BRIGHT_HIGH_RST;
    set_window      = DUP_WINDOW_RST;
    set_max_ham     = MAX_HAM_RST;
    win_count       = 0;
    kept_total      = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings.
    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].frame, directed_rows[r].typed, directed_rows[r].verdict);
    end

    // Random phases, each with its own register settings.
    now_ms = 40'd3000;
    for (int p = 0; p < PHASES; p++) begin
      in_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      s = phase_settings[p];
      if (s.pick_random) begin
        s.min_sharp   = CFG_DATA_W'($urandom_range(0, Q_MAX));
        s.bright_low  = CFG_DATA_W'($urandom_range(0, Q_MAX));
        s.bright_high = CFG_DATA_W'($urandom_range(0, Q_MAX));
        s.window      = CFG_DATA_W'($urandom_range(0, Q_MAX));
        s.max_ham     = CFG_DATA_W'($urandom_range(0, Q_MAX));
      end
      program_settings(s);
      gaps_enabled = (p != QUIET_PHASE);
      stalls_enabled <= (p != QUIET_PHASE);
      if (p == TOP_TIME_PHASE) begin
        now_ms = TIME_TOP_BASE;
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == HOLD_PHASE && k == HOLD_AT_ITEM) begin
          hold_request <= 1'b1;
        end

        // Timestamps mostly climb, sometimes repeat, rarely step back.
        pick = $urandom_range(0, 99);
        if (pick < 3 && now_ms > 64) begin
          now_ms = now_ms - TIME_W'($urandom_range(1, 64));
        end else if (pick >= 15) begin
          stride = TIME_W'($urandom_range(1, int'(set_window) / 4 + 2));
          now_ms = (TIME_TOP - now_ms > stride) ? now_ms + stride : TIME_TOP;
        end
        f.time_ms = now_ms;

        // Near copies of recent hashes make duplicates likely.
        if (recent_hashes.size() != 0 && $urandom_range(0, 99) < 45) begin
          hash  = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
          flips = $urandom_range(0, (set_max_ham > 8) ? 10 : int'(set_max_ham) + 2);
          repeat (flips) begin
            bitpos = $urandom_range(0, HASH_W - 1);
            hash[bitpos] = ~hash[bitpos];
          end
        end else begin
          hash = {$urandom, $urandom};
        end
        recent_hashes.push_back(hash);
        if (recent_hashes.size() > 8) begin
          void'(recent_hashes.pop_front());
        end
        f.hash = hash;

        // Quality values cluster at the thresholds and above 1.0.
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          f.sharpness = Q_W'($urandom_range(int'(Q_ONE), Q_MAX));
        end else if (pick < 20) begin
          f.sharpness = set_min_sharp - Q_W'($urandom_range(0, 1));
        end else begin
          f.sharpness = Q_W'($urandom_range(0, int'(Q_ONE)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          f.brightness = set_bright_low - Q_W'($urandom_range(0, 1));
        end else if (pick < 20) begin
          f.brightness = set_bright_high + Q_W'($urandom_range(0, 1));
        end else if (pick < 28) begin
          f.brightness = Q_W'($urandom_range(int'(Q_ONE), Q_MAX));
        end else begin
          f.brightness = Q_W'($urandom_range(0, int'(Q_ONE)));
        end
        f.image_ok = ($urandom_range(0, 99) < 90);
        f.anchor   = ($urandom_range(0, 99) < 10);
        send_frame(f, 1'b0, '0);
      end
    end

    // Let every outstanding result item arrive.
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
